### sv/multichannel_conv2d_same_macros.svh
// Assertion helpers for the convolution block checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MULTICHANNEL_CONV2D_SAME_MACROS_SVH
`define MULTICHANNEL_CONV2D_SAME_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define MCONV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define MCONV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/mconv_pkg.sv
`timescale 1ns / 1ps

package mconv_pkg;

  // Array geometry.
  localparam int IMAGE_SIZE  = 3;
  localparam int KERNEL_SIZE = 3;
  localparam int CHANNELS    = 3;
  localparam int CENTER      = KERNEL_SIZE / 2;

  // Field widths of the channels.
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 2;
  localparam int VALUE_W = 16;
  localparam int SUM_W   = 36;
  localparam int PROD_W  = 2 * VALUE_W;

  // Counter and address widths.
  localparam int POS_W  = (IMAGE_SIZE > 1) ? $clog2(IMAGE_SIZE) : 1;
  localparam int TAP_W  = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int KDEPTH = KERNEL_SIZE * KERNEL_SIZE * CHANNELS;
  localparam int IDEPTH = IMAGE_SIZE * IMAGE_SIZE * CHANNELS;
  localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int IAW    = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;

  // Signed width for image offsets, covers row + center - tap over the whole range.
  localparam int OFF_W = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_KERNEL = 2'd0,
    MODE_LOAD_IMAGE  = 2'd1,
    MODE_COMPUTE     = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_t;

  // Control that travels with one tap through the multiply-accumulate pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic inb;
  } tap_ctl_t;

endpackage

### sv/mconv_if.sv
`timescale 1ns / 1ps

// Input channel: one load or compute word.
interface mconv_in_if;
  import mconv_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [IDX_W-1:0]          row;
  logic [IDX_W-1:0]          col;
  logic [IDX_W-1:0]          channel;
  logic signed [VALUE_W-1:0] value;

  modport source(output valid, mode, row, col, channel, value, input ready);
  modport sink(input valid, mode, row, col, channel, value, output ready);
  modport mon(input valid, ready, mode, row, col, channel, value);
endinterface

// Result channel: one convolution sum per image position.
interface mconv_out_if;
  import mconv_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [SUM_W-1:0] sum;
  logic                    last;

  modport source(output valid, out_row, out_col, sum, last, input ready);
  modport sink(input valid, out_row, out_col, sum, last, output ready);
  modport mon(input valid, ready, out_row, out_col, sum, last);
endinterface

### sv/mconv_mac.sv
`timescale 1ns / 1ps

// Shared multiply-accumulate unit: one product register, one accumulator.
module mconv_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mconv_pkg::tap_ctl_t                   s1_ctl,
  input  logic signed [mconv_pkg::VALUE_W-1:0]  kern,
  input  logic signed [mconv_pkg::VALUE_W-1:0]  samp,
  input  logic                                  clear,
  output logic signed [mconv_pkg::SUM_W-1:0]    acc,
  output logic                                  done
);
  import mconv_pkg::*;

  tap_ctl_t                 s2_ctl_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [SUM_W-1:0]  acc_r;
  logic signed [SUM_W-1:0]  acc_nxt;
  logic                     done_r;
  logic                     done_nxt;

  // Taps that fall outside the image contribute zero.
  assign prod     = kern * samp;
  assign prod_nxt = s1_ctl.inb ? prod : '0;

  // The first tap of a position restarts the sum.
  always_comb begin
    acc_nxt  = acc_r;
    done_nxt = done_r;
    if (s2_ctl_r.valid) begin
      if (s2_ctl_r.first) begin
        acc_nxt = SUM_W'(prod_r);
      end else begin
        acc_nxt = acc_r + SUM_W'(prod_r);
      end
    end
    if (s2_ctl_r.valid && s2_ctl_r.last) begin
      done_nxt = 1'b1;
    end else if (clear) begin
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
      acc_r    <= '0;
      done_r   <= 1'b0;
    end else begin
      s2_ctl_r <= s1_ctl;
      acc_r    <= acc_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

### sv/multichannel_conv2d_same.sv
`timescale 1ns / 1ps

// Multichannel 3x3 "same" convolution with zero padding.
// in_word carries one word per handshake: mode 0 writes a kernel weight and
// mode 1 an image sample at (row, col, channel); neither produces
// anything. Words whose indexes fall outside the stores, and mode 3,
// are dropped. Mode 2 starts a compute run that emits one out_word per image
// position, row-major, with last set on the final one.
// Each position runs 27 taps (channels times kernel taps) through one shared
// multiply-accumulate unit, one tap a cycle, then drains its pipeline
// (memory read, product, accumulate) before the sum is ready. The sequencer
// starts the next position only after that sum has moved to the output
// register, so positions do not overlap.
// in_word.ready is high only between runs, so a run occupies the block.
// A finished result sits in the output register; if out_word.ready is low
// the next result is held in the accumulator and the sequencer waits.
// Reset (rst_n low, synchronous) returns to idle with no result pending; the
// stores are not cleared and must be written before a compute reads them.
module multichannel_conv2d_same (
  input  logic         clk,
  input  logic         rst_n,
  mconv_in_if.sink     in_word,
  mconv_out_if.source  out_word
);
  import mconv_pkg::*;

  state_t state_r, state_nxt;

  logic [POS_W-1:0] r_r, r_nxt;
  logic [POS_W-1:0] c_r, c_nxt;
  logic [TAP_W-1:0] m_r, m_nxt;
  logic [TAP_W-1:0] n_r, n_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;

  logic                      in_acc;
  logic                      kwe;
  logic                      iwe;
  logic [KAW-1:0]            kaddr_ld;
  logic [IAW-1:0]            iaddr_ld;
  logic [KAW-1:0]            kaddr_rd;
  logic [IAW-1:0]            iaddr_rd;
  logic signed [OFF_W-1:0]   ir;
  logic signed [OFF_W-1:0]   ic;
  logic                      tap_last;
  logic                      pos_last;
  tap_ctl_t                  s0_ctl;
  tap_ctl_t                  s1_ctl_r;

  logic signed [VALUE_W-1:0] kmem [KDEPTH];
  logic signed [VALUE_W-1:0] imem [IDEPTH];
  logic signed [VALUE_W-1:0] k_q_r;
  logic signed [VALUE_W-1:0] i_q_r;

  logic signed [SUM_W-1:0]   acc;
  logic                      done;
  logic                      load;

  logic                      out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]          out_row_r;
  logic [IDX_W-1:0]          out_col_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic                      last_r;

  assign in_word.ready = (state_r == ST_IDLE);
  assign in_acc        = in_word.valid && in_word.ready;

  // Load addresses, row-major with channel innermost.
  assign kaddr_ld = KAW'((int'(in_word.row) * KERNEL_SIZE + int'(in_word.col)) * CHANNELS
                         + int'(in_word.channel));
  assign iaddr_ld = IAW'((int'(in_word.row) * IMAGE_SIZE + int'(in_word.col)) * CHANNELS
                         + int'(in_word.channel));

  // Image position under the current tap of the rotated kernel.
  assign ir = $signed(OFF_W'(r_r)) + $signed(OFF_W'(CENTER)) - $signed(OFF_W'(m_r));
  assign ic = $signed(OFF_W'(c_r)) + $signed(OFF_W'(CENTER)) - $signed(OFF_W'(n_r));

  assign s0_ctl.valid = (state_r == ST_RUN);
  assign s0_ctl.first = (ch_r == '0) && (m_r == '0) && (n_r == '0);
  assign s0_ctl.last  = tap_last;
  assign s0_ctl.inb   = (ir >= 0) && (ir < IMAGE_SIZE) && (ic >= 0) && (ic < IMAGE_SIZE);

  assign tap_last = (ch_r == CH_W'(CHANNELS - 1)) && (m_r == TAP_W'(KERNEL_SIZE - 1))
                    && (n_r == TAP_W'(KERNEL_SIZE - 1));
  assign pos_last = (r_r == POS_W'(IMAGE_SIZE - 1)) && (c_r == POS_W'(IMAGE_SIZE - 1));

  assign kaddr_rd = KAW'((int'(m_r) * KERNEL_SIZE + int'(n_r)) * CHANNELS + int'(ch_r));
  assign iaddr_rd = s0_ctl.inb ?
                    IAW'((int'(ir) * IMAGE_SIZE + int'(ic)) * CHANNELS + int'(ch_r)) : '0;

  // A finished sum moves to the output register once that register is free.
  assign load = (state_r == ST_WAIT) && done && (!out_valid_r || out_word.ready);

  // Sequencer: next state, counters and store write enables.
  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    m_nxt     = m_r;
    n_nxt     = n_r;
    ch_nxt    = ch_r;
    kwe       = 1'b0;
    iwe       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (mode_t'(in_word.mode))
            MODE_LOAD_KERNEL: begin
              kwe = (in_word.row < KERNEL_SIZE) && (in_word.col < KERNEL_SIZE)
                    && (in_word.channel < CHANNELS);
            end
            MODE_LOAD_IMAGE: begin
              iwe = (in_word.row < IMAGE_SIZE) && (in_word.col < IMAGE_SIZE)
                    && (in_word.channel < CHANNELS);
            end
            MODE_COMPUTE: begin
              state_nxt = ST_RUN;
              r_nxt     = '0;
              c_nxt     = '0;
              m_nxt     = '0;
              n_nxt     = '0;
              ch_nxt    = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (n_r == TAP_W'(KERNEL_SIZE - 1)) begin
          n_nxt = '0;
          if (m_r == TAP_W'(KERNEL_SIZE - 1)) begin
            m_nxt = '0;
            if (ch_r == CH_W'(CHANNELS - 1)) begin
              ch_nxt = '0;
            end else begin
              ch_nxt = ch_r + 1'b1;
            end
          end else begin
            m_nxt = m_r + 1'b1;
          end
        end else begin
          n_nxt = n_r + 1'b1;
        end
        if (tap_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (load) begin
          if (pos_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_RUN;
            if (c_r == POS_W'(IMAGE_SIZE - 1)) begin
              c_nxt = '0;
              r_nxt = r_r + 1'b1;
            end else begin
              c_nxt = c_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      r_r      <= '0;
      c_r      <= '0;
      m_r      <= '0;
      n_r      <= '0;
      ch_r     <= '0;
      s1_ctl_r <= '0;
    end else begin
      state_r  <= state_nxt;
      r_r      <= r_nxt;
      c_r      <= c_nxt;
      m_r      <= m_nxt;
      n_r      <= n_nxt;
      ch_r     <= ch_nxt;
      s1_ctl_r <= s0_ctl;
    end
  end

  // Kernel and image stores, one write and one registered read each.
  always_ff @(posedge clk) begin
    if (kwe) begin
      kmem[kaddr_ld] <= in_word.value;
    end
    k_q_r <= kmem[kaddr_rd];
  end

  always_ff @(posedge clk) begin
    if (iwe) begin
      imem[iaddr_ld] <= in_word.value;
    end
    i_q_r <= imem[iaddr_rd];
  end

  mconv_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .s1_ctl (s1_ctl_r),
    .kern   (k_q_r),
    .samp   (i_q_r),
    .clear  (load),
    .acc    (acc),
    .done   (done)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row_r <= IDX_W'(r_r);
      out_col_r <= IDX_W'(c_r);
      sum_r     <= acc;
      last_r    <= pos_last;
    end
  end

  assign out_word.valid   = out_valid_r;
  assign out_word.out_row = out_row_r;
  assign out_word.out_col = out_col_r;
  assign out_word.sum     = sum_r;
  assign out_word.last    = last_r;

endmodule

### sv/mconv_chk.sv
`timescale 1ns / 1ps
`include "multichannel_conv2d_same_macros.svh"

// Port-level checks for the convolution block.
module mconv_chk (
  input logic         clk,
  input logic         rst_n,
  mconv_in_if.sink    in_word,
  mconv_out_if.source out_word
);
  import mconv_pkg::*;

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_word.valid && in_word.ready;
  assign out_acc = out_word.valid && out_word.ready;

  // A result that is not taken stays on the port with its sum and last flag unchanged.
  `MCONV_ASSERT_NEXT(a_out_hold, out_word.valid && !out_word.ready, out_word.valid && $stable(out_word.sum) && $stable(out_word.last), "stalled result changed")

  // A compute run occupies the block right after it is accepted.
  `MCONV_ASSERT_NEXT(a_busy_after_compute, in_acc && (in_word.mode == MODE_COMPUTE), !in_word.ready, "input ready during a compute run")

  // Loads and dropped words never produce a result.
  `MCONV_ASSERT_NEXT(a_load_silent, in_acc && (in_word.mode != MODE_COMPUTE) && !out_word.valid, !out_word.valid, "result appeared after a load")

  // Nothing follows the final result of a run directly.
  `MCONV_ASSERT_NEXT(a_last_ends_run, out_acc && out_word.last, !out_word.valid, "result after the final one of a run")

  // The final result belongs to the last image position.
  `MCONV_ASSERT_SAME(a_last_position, out_word.valid && out_word.last, (out_word.out_row == IDX_W'(IMAGE_SIZE - 1)) && (out_word.out_col == IDX_W'(IMAGE_SIZE - 1)), "final result at wrong position")

endmodule

bind multichannel_conv2d_same mconv_chk u_mconv_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_word  (in_word),
  .out_word (out_word)
);
